// ===== rtl/ordered_list_insert_delete_unit_assert.svh =====
// Assertion macros for the ordered list unit
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define OLID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define OLID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/olid_pkg.sv =====
// Shared types and constants for the ordered list unit
package olid_pkg;

  localparam int VAL_W          = 32;
  localparam int OP_W           = 3;
  localparam int POS_W          = 6;
  localparam int ST_W           = 2;
  localparam int TOT_W          = 5;
  localparam int LIST_DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] tail;
  } cell_ctl_t;

endpackage

// ===== rtl/olid_in_if.sv =====
// Input channel: one list command per beat
interface olid_in_if;
  logic                                valid;
  logic                                ready;
  logic [olid_pkg::OP_W-1:0]           opcode;
  logic signed [olid_pkg::VAL_W-1:0]   new_value;
  logic [olid_pkg::POS_W-1:0]          position;

  modport source (output valid, opcode, new_value, position, input ready);
  modport sink (input valid, opcode, new_value, position, output ready);
endinterface

// ===== rtl/olid_out_if.sv =====
// Output channel: one result per beat
interface olid_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [olid_pkg::VAL_W-1:0]   entry_value;
  logic [olid_pkg::ST_W-1:0]           status;
  logic                                last_of_run;
  logic [olid_pkg::TOT_W-1:0]          entry_total;

  modport source (output valid, entry_value, status, last_of_run, entry_total, input ready);
  modport sink (input valid, entry_value, status, last_of_run, entry_total, output ready);
endinterface

// ===== rtl/olid_cell.sv =====
// One list cell: holds an entry and takes from its neighbours on shifts
module olid_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  olid_pkg::cell_ctl_t               ctl,
  input  logic signed [olid_pkg::VAL_W-1:0] new_value,
  input  logic signed [olid_pkg::VAL_W-1:0] left_value,
  input  logic signed [olid_pkg::VAL_W-1:0] right_value,
  input  logic signed [olid_pkg::VAL_W-1:0] head_value,
  output logic signed [olid_pkg::VAL_W-1:0] value
);
  import olid_pkg::*;

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INSERT: begin
        if (IDX == ctl.pos) begin
          value <= new_value;
        end else if (IDX > ctl.pos) begin
          value <= left_value;
        end
      end
      CELL_DELETE: begin
        if (IDX >= ctl.pos) begin
          value <= right_value;
        end
      end
      CELL_ROTATE: begin
        value <= (IDX == ctl.tail) ? head_value : right_value;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/ordered_list_insert_delete_unit.sv =====
// Top level of the ordered list unit: command decode, cell chain, result register
//
// Usage:
//   item_in carries one command per beat (opcode, new_value, position).
//   result_out carries results (entry_value, status, last_of_run, entry_total).
//   An edit (insert or delete) gives one result in the cycle after its beat is
//   taken; a new command is taken in every cycle while the result register
//   is free or being drained, so edits run at one beat per cycle.
//   A dump enters the dump state, then gives one entry per cycle while not
//   stalled, as the cells rotate the list past cell 0 and back into place.
//   A dump of an empty list gives one result in the cycle after its beat, with
//   status empty.
//   The cells shift all entries in parallel, so an edit at any position
//   is done in one shift of the chain, whatever its place in the list.
//   Reset (rst, synchronous) empties the list and drops any pending result.
//   When result_out.ready is low, the pending result holds and item_in.ready
//   falls; a dump pauses its rotation until the receiver takes the beat.
module ordered_list_insert_delete_unit #(
  parameter int LIST_DEPTH = olid_pkg::LIST_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  olid_in_if.sink    item_in,
  olid_out_if.source result_out
);
  import olid_pkg::*;

  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [CW-1:0]           didx;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  status_t                 out_status;
  logic                    out_last;
  logic [TOT_W-1:0]        out_total;

  logic                    fire;
  logic                    out_free;
  logic                    is_ins;
  logic                    is_del;
  logic                    is_dump;
  logic                    full;
  logic                    empty;
  logic [CMP_W-1:0]        ins_pos;
  logic [CMP_W-1:0]        del_pos;
  logic [CMP_W-1:0]        cnt_ext;
  status_t                 edit_status;
  logic                    ins_ok;
  logic                    del_ok;
  logic                    dump_last;
  cell_ctl_t               cell_ctl;
  logic signed [VAL_W-1:0] cell_q [LIST_DEPTH];

  assign out_free      = !out_valid || result_out.ready;
  assign item_in.ready = (state == S_IDLE) && out_free;
  assign fire          = item_in.valid && item_in.ready;
  assign full          = (count == CW'(LIST_DEPTH));
  assign empty         = (count == '0);
  assign cnt_ext       = CMP_W'(count);

  always_comb begin
    is_ins      = 1'b0;
    is_del      = 1'b0;
    is_dump     = 1'b0;
    ins_pos     = '0;
    del_pos     = '0;
    edit_status = ST_OK;
    unique case (item_in.opcode)
      OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      OP_INS_END: begin
        is_ins  = 1'b1;
        ins_pos = cnt_ext;
      end
      OP_INS_AT: begin
        is_ins  = 1'b1;
        ins_pos = CMP_W'(item_in.position);
      end
      OP_DEL_FIRST: begin
        is_del = 1'b1;
      end
      OP_DEL_END: begin
        is_del  = 1'b1;
        del_pos = cnt_ext - CMP_W'(1);
      end
      OP_DEL_AT: begin
        is_del  = 1'b1;
        del_pos = CMP_W'(item_in.position);
      end
      OP_DUMP: begin
        is_dump = 1'b1;
      end
      default: ;
    endcase
    priority if (is_ins) begin
      if (full) begin
        edit_status = ST_FULL;
      end else if (ins_pos > cnt_ext) begin
        edit_status = ST_OOB;
      end
    end else if (is_del) begin
      if (empty) begin
        edit_status = ST_EMPTY;
      end else if (del_pos >= cnt_ext) begin
        edit_status = ST_OOB;
      end
    end else begin
      edit_status = ST_OK;
    end
  end

  assign ins_ok    = is_ins && (edit_status == ST_OK);
  assign del_ok    = is_del && (edit_status == ST_OK);
  assign dump_last = (didx == count - CW'(1));

  always_comb begin
    count_next = count;
    if (fire && ins_ok) begin
      count_next = count + CW'(1);
    end else if (fire && del_ok) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    cell_ctl.op   = CELL_HOLD;
    cell_ctl.pos  = '0;
    cell_ctl.tail = POS_W'(count - CW'(1));
    priority if (fire && ins_ok) begin
      cell_ctl.op  = CELL_INSERT;
      cell_ctl.pos = POS_W'(ins_pos);
    end else if (fire && del_ok) begin
      cell_ctl.op  = CELL_DELETE;
      cell_ctl.pos = POS_W'(del_pos);
    end else if ((state == S_DUMP) && out_free) begin
      cell_ctl.op = CELL_ROTATE;
    end else begin
      cell_ctl.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_value = item_in.new_value;
    end else begin : g_inner_l
      assign left_value = cell_q[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_value = cell_q[i];
    end else begin : g_inner_r
      assign right_value = cell_q[i+1];
    end
    olid_cell #(
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .new_value   (item_in.new_value),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_q[0]),
      .value       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      didx      <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (result_out.valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (fire) begin
            if (is_dump && !empty) begin
              state <= S_DUMP;
              didx  <= '0;
            end else begin
              out_valid  <= 1'b1;
              out_value  <= '0;
              out_status <= is_dump ? ST_EMPTY : edit_status;
              out_last   <= 1'b1;
              out_total  <= TOT_W'(count_next);
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_value  <= cell_q[0];
            out_status <= ST_OK;
            out_last   <= dump_last;
            out_total  <= TOT_W'(count);
            didx       <= didx + CW'(1);
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.entry_value = out_value;
  assign result_out.status      = out_status;
  assign result_out.last_of_run = out_last;
  assign result_out.entry_total = out_total;

  `include "ordered_list_insert_delete_unit_assert.svh"

  `OLID_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(LIST_DEPTH), "entry count beyond depth")
  `OLID_ASSERT_NXT(a_count_hold, !fire, count == $past(count), "count moved without a beat")
  `OLID_ASSERT_IMP(a_dump_idx, state == S_DUMP, didx < count, "dump index past the list")
  `OLID_ASSERT_NXT(a_dump_end, (state == S_DUMP) && out_free && dump_last, state == S_IDLE, "dump did not end on its last entry")
  `OLID_ASSERT_IMP(a_empty_total, result_out.valid && (result_out.status == ST_EMPTY), result_out.entry_total == '0, "empty status with entries")

endmodule

// ===== sim/tb.sv =====
// Testbench for the ordered list unit: directed and random commands against a shadow list
`timescale 1ns / 100ps

module tb;
  import olid_pkg::*;

  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_LINES = 60;

  typedef struct {
    logic signed [VAL_W-1:0] entry_value;
    status_t                 status;
    logic                    last_of_run;
    logic [TOT_W-1:0]        entry_total;
  } list_reply_t;

  class list_shadow;
    logic signed [VAL_W-1:0] cells[$];
    list_reply_t             due_replies[$];
    int                      errors;
    int                      cmds;
    int                      replies;
    int                      full_hits;
    int                      empty_hits;

    function new();
      errors = 0;
      cmds = 0;
      replies = 0;
      full_hits = 0;
      empty_hits = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_LINES) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function void push_reply(logic signed [VAL_W-1:0] v, status_t st, logic last);
      list_reply_t r;
      r.entry_value = v;
      r.status = st;
      r.last_of_run = last;
      r.entry_total = TOT_W'(cells.size());
      due_replies.push_back(r);
    endfunction

    function void take_cmd(op_t op, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
      status_t st;
      int n;
      int at;
      st = ST_OK;
      n = cells.size();
      cmds++;
      case (op)
        OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
          at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_END) ? n : int'(p);
          if (n >= DEPTH) begin
            st = ST_FULL;
            full_hits++;
          end else if (at > n) begin
            st = ST_OOB;
          end else begin
            cells.insert(at, v);
          end
        end
        OP_DEL_FIRST, OP_DEL_END, OP_DEL_AT: begin
          at = (op == OP_DEL_FIRST) ? 0 : (op == OP_DEL_END) ? n - 1 : int'(p);
          if (n == 0) begin
            st = ST_EMPTY;
            empty_hits++;
          end else if (at >= n) begin
            st = ST_OOB;
          end else begin
            cells.delete(at);
          end
        end
        OP_DUMP: begin
          if (n == 0) begin
            push_reply('0, ST_EMPTY, 1'b1);
            empty_hits++;
          end else begin
            foreach (cells[i]) push_reply(cells[i], ST_OK, i == n - 1);
          end
          return;
        end
        default: ;
      endcase
      push_reply('0, st, 1'b1);
    endfunction

    task match_reply(logic signed [VAL_W-1:0] v, logic [ST_W-1:0] st, logic last,
                     logic [TOT_W-1:0] total);
      list_reply_t e;
      replies++;
      if (due_replies.size() == 0) begin
        report($sformatf("unexpected reply value %0d status %0d", v, st));
      end else begin
        e = due_replies.pop_front();
        if (v !== e.entry_value)
          report($sformatf("entry_value %0d, want %0d", v, e.entry_value));
        if (st !== e.status)
          report($sformatf("status %0d, want %0d", st, e.status));
        if (last !== e.last_of_run)
          report($sformatf("last_of_run %0b, want %0b", last, e.last_of_run));
        if (total !== e.entry_total)
          report($sformatf("entry_total %0d, want %0d", total, e.entry_total));
      end
    endtask

    function int due_count();
      return due_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   gap_pct;
  int   stall_pct;
  int   quiet_cycles;

  olid_in_if  item_if ();
  olid_out_if reply_if ();

  list_shadow shadow;

  ordered_list_insert_delete_unit #(.LIST_DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_if),
    .result_out(reply_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready)
        shadow.take_cmd(op_t'(item_if.opcode), item_if.new_value, item_if.position);
      if (reply_if.valid && reply_if.ready)
        shadow.match_reply(reply_if.entry_value, reply_if.status, reply_if.last_of_run,
                           reply_if.entry_total);
    end
    reply_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (reply_if.valid && reply_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: no beat for %0d cycles, %0d replies still due", quiet_cycles,
                 shadow.due_count());
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic send_cmd(op_t op, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    item_if.valid     <= 1'b1;
    item_if.opcode    <= op;
    item_if.new_value <= v;
    item_if.position  <= p;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
  endtask

  task automatic send_random(bit grow);
    op_t                     op;
    int                      r;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0]        p;
    r = $urandom_range(99);
    if (r < 10) op = OP_DUMP;
    else if (r < (grow ? 75 : 35)) op = op_t'($urandom_range(OP_INS_AT, OP_INS_FRONT));
    else op = op_t'($urandom_range(OP_DEL_AT, OP_DEL_FIRST));
    case ($urandom_range(9))
      0: v = {1'b1, {(VAL_W-1){1'b0}}};
      1: v = {1'b0, {(VAL_W-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
    p = ($urandom_range(9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(DEPTH + 1));
    send_cmd(op, v, p);
  endtask

  initial begin
    shadow = new();
    rst = 1'b1;
    gap_pct = 0;
    stall_pct = 0;
    item_if.valid     <= 1'b0;
    item_if.opcode    <= '0;
    item_if.new_value <= '0;
    item_if.position  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(OP_DUMP,      '0, '0);
    send_cmd(OP_DEL_FIRST, '0, '0);
    send_cmd(OP_DEL_END,   '0, '0);
    send_cmd(OP_DEL_AT,    '0, '0);
    send_cmd(OP_INS_AT,    32'sd5, 6'd1);
    send_cmd(OP_INS_FRONT, {1'b1, {(VAL_W-1){1'b0}}}, 6'd63);
    send_cmd(OP_INS_END,   {1'b0, {(VAL_W-1){1'b1}}}, 6'd0);
    send_cmd(OP_INS_AT,    '1, 6'd1);
    send_cmd(OP_INS_AT,    '0, 6'd3);
    send_cmd(OP_INS_AT,    32'sh5a5a_a5a5, 6'd5);
    send_cmd(OP_INS_AT,    32'sh1234_5678, 6'd63);
    send_cmd(OP_DUMP,      '0, '0);
    send_cmd(OP_DEL_AT,    '0, 6'd4);
    send_cmd(OP_DEL_AT,    '0, 6'd63);
    send_cmd(OP_DEL_AT,    '0, 6'd1);
    send_cmd(OP_DEL_END,   '0, '0);
    send_cmd(OP_DUMP,      '0, '0);
    send_cmd(OP_DEL_FIRST, '0, '0);
    send_cmd(OP_DEL_AT,    '0, 6'd0);
    send_cmd(OP_DUMP,      '0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      for (int i = 0; i < 50; i++) send_random(((phase * 50 + i) / 25) % 2 == 0);
    end

    item_if.valid <= 1'b0;
    while (shadow.due_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb: %0d commands, %0d replies checked", shadow.cmds, shadow.replies);
    $display("tb: full list met %0d times, empty list met %0d times, %0d mismatches",
             shadow.full_hits, shadow.empty_hits, shadow.errors);
    if (shadow.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
